// ===== rtl/quaternion_to_heading_defines.svh =====
// Assertion macros for the quaternion_to_heading top level.
`ifndef QUATERNION_TO_HEADING_DEFINES_SVH
`define QUATERNION_TO_HEADING_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define QTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define QTH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qth_pkg.sv =====
// Shared types, constants and the arctangent table for quaternion_to_heading.
package qth_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int NUM_PRODUCTS     = 12;

  // quaternion product sequence
  localparam logic [3:0] P_JR = 4'd0;
  localparam logic [3:0] P_IK = 4'd1;
  localparam logic [3:0] P_II = 4'd2;
  localparam logic [3:0] P_JJ = 4'd3;
  localparam logic [3:0] P_KK = 4'd4;
  localparam logic [3:0] P_RR = 4'd5;
  localparam logic [3:0] P_IJ = 4'd6;
  localparam logic [3:0] P_KR = 4'd7;
  localparam logic [3:0] P_JK = 4'd8;
  localparam logic [3:0] P_IR = 4'd9;
  localparam logic [3:0] P_NN = 4'd10;
  localparam logic [3:0] P_SS = 4'd11;

  // angle selected for the shared CORDIC
  localparam logic [1:0] SEL_YAW   = 2'd0;
  localparam logic [1:0] SEL_ROLL  = 2'd1;
  localparam logic [1:0] SEL_PITCH = 2'd2;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [31:0] atan_entry(input logic [4:0] idx, input int angle_bits);
    logic [31:0] lowmask;
    logic [31:0] half;
    lowmask = (32'd1 << (32 - angle_bits)) - 32'd1;
    half    = 32'd1 << (31 - angle_bits);
    return (ATAN_TABLE[idx] + half) & ~lowmask;
  endfunction

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [3:0] mul_idx;
    logic       acc_en;
    logic [3:0] acc_idx;
    logic       sqrt_step;
    logic [4:0] sqrt_idx;
    logic [1:0] cd_sel;
    logic       cd_init;
    logic       cd_step;
    logic [4:0] cd_idx;
    logic       cd_store;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/qth_ctrl.sv =====
// Sequencer: products, square root, then three CORDIC passes per rotation event.
module qth_ctrl #(
  parameter int CORDIC_STEPS = qth_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qth_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output qth_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_CORD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          sel_d      = qth_pkg::SEL_YAW;
          state_d    = sts_i.in_kind ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        // accumulate takes the product registered by the multiplier in the previous cycle
        cmd_o.mul_en  = (cnt_q < 6'(qth_pkg::NUM_PRODUCTS));
        cmd_o.mul_idx = cnt_q[3:0];
        cmd_o.acc_en  = (cnt_q != '0);
        cmd_o.acc_idx = cnt_q[3:0] - 4'd1;
        if (cnt_q == 6'(qth_pkg::NUM_PRODUCTS)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.sqrt_idx  = cnt_q[4:0];
        if (cnt_q == 6'd31) begin
          cnt_d   = '0;
          state_d = ST_CORD;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_CORD: begin
        cmd_o.cd_sel = sel_q;
        cmd_o.cd_idx = 5'(cnt_q - 6'd1);
        if (cnt_q == '0) begin
          cmd_o.cd_init = 1'b1;
          cnt_d         = cnt_q + 6'd1;
        end else if (cnt_q <= 6'(CORDIC_STEPS)) begin
          cmd_o.cd_step = 1'b1;
          cnt_d         = cnt_q + 6'd1;
        end else begin
          cmd_o.cd_store = 1'b1;
          cnt_d          = '0;
          if (sel_q == qth_pkg::SEL_PITCH) begin
            state_d = ST_FIN;
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= qth_pkg::SEL_YAW;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ===== rtl/qth_datapath.sv =====
// Datapath: shared multiplier, integer square root, shared CORDIC and output holds.
module qth_datapath #(
  parameter int ANGLE_BITS = qth_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qth_pkg::cmd_t      cmd_i,
  input  logic               in_kind_i,
  input  logic signed [15:0] quat_i_i,
  input  logic signed [15:0] quat_j_i,
  input  logic signed [15:0] quat_k_i,
  input  logic signed [15:0] quat_real_i,
  input  logic [1:0]         accuracy_in_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [15:0]        heading_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic [1:0]         mag_accuracy_o
);

  localparam int AW = 34;  // product sums
  localparam int MW = 33;  // multiplier operands
  localparam int CW = 38;  // CORDIC x/y

  logic [15:0] offset_q;
  logic        kind_q;
  logic [1:0]  acc_in_q;
  logic signed [15:0] qi_q, qj_q, qk_q, qr_q;

  logic signed [63:0]   p_q;
  logic signed [AW-1:0] yy_q, yx_q, ry_q, rx_q, n_q, s_q;
  logic [63:0] rad_q, root_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [31:0] ang_q;
  logic        zz_q;
  logic [15:0] yaw_r_q, roll_r_q, pitch_r_q;
  logic [15:0] heading_q, yaw_q, pitch_q, roll_q;
  logic [1:0]  acc_hold_q;
  logic        out_valid_q;

  // pitch operands: floor halves, |s| clipped to n
  logic signed [MW-1:0] nh, sh, sa_raw, sa, sh_sat;
  logic sat;
  always_comb begin
    nh     = MW'(n_q >>> 1);
    sh     = MW'(s_q >>> 1);
    sa_raw = sh[MW-1] ? -sh : sh;
    sat    = (sa_raw > nh);
    sa     = sat ? nh : sa_raw;
    sh_sat = sat ? (sh[MW-1] ? -nh : nh) : sh;
  end

  logic signed [MW-1:0] mul_a, mul_b;
  always_comb begin
    unique case (cmd_i.mul_idx)
      qth_pkg::P_JR: begin mul_a = MW'(qj_q); mul_b = MW'(qr_q); end
      qth_pkg::P_IK: begin mul_a = MW'(qi_q); mul_b = MW'(qk_q); end
      qth_pkg::P_II: begin mul_a = MW'(qi_q); mul_b = MW'(qi_q); end
      qth_pkg::P_JJ: begin mul_a = MW'(qj_q); mul_b = MW'(qj_q); end
      qth_pkg::P_KK: begin mul_a = MW'(qk_q); mul_b = MW'(qk_q); end
      qth_pkg::P_RR: begin mul_a = MW'(qr_q); mul_b = MW'(qr_q); end
      qth_pkg::P_IJ: begin mul_a = MW'(qi_q); mul_b = MW'(qj_q); end
      qth_pkg::P_KR: begin mul_a = MW'(qk_q); mul_b = MW'(qr_q); end
      qth_pkg::P_JK: begin mul_a = MW'(qj_q); mul_b = MW'(qk_q); end
      qth_pkg::P_IR: begin mul_a = MW'(qi_q); mul_b = MW'(qr_q); end
      qth_pkg::P_NN: begin mul_a = nh;        mul_b = nh;        end
      qth_pkg::P_SS: begin mul_a = sa;        mul_b = sa;        end
      default:       begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  logic signed [AW-1:0] pa, p2;
  assign pa = AW'(p_q);
  assign p2 = pa <<< 1;

  // integer square root, two radicand bits and one root bit per step
  logic [63:0] sq_bit, sq_trial;
  assign sq_bit   = 64'd1 << (7'd62 - {1'b0, cmd_i.sqrt_idx, 1'b0});
  assign sq_trial = root_q + sq_bit;

  // CORDIC
  logic signed [CW-1:0] in_x, in_y, dx, dy;
  logic [31:0] te, ang_rnd;
  logic [15:0] cd_res;
  always_comb begin
    unique case (cmd_i.cd_sel)
      qth_pkg::SEL_YAW:   begin in_y = CW'(yy_q);   in_x = CW'(yx_q); end
      qth_pkg::SEL_ROLL:  begin in_y = CW'(ry_q);   in_x = CW'(rx_q); end
      qth_pkg::SEL_PITCH: begin in_y = CW'(sh_sat); in_x = CW'({1'b0, root_q[31:0]}); end
      default:            begin in_y = '0;          in_x = '0;        end
    endcase
  end
  assign dx      = cy_q >>> cmd_i.cd_idx;
  assign dy      = cx_q >>> cmd_i.cd_idx;
  assign te      = qth_pkg::atan_entry(cmd_i.cd_idx, ANGLE_BITS);
  assign ang_rnd = ang_q + 32'h0000_8000;
  assign cd_res  = zz_q ? 16'd0 : ang_rnd[31:16];

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= in_kind_i;
      acc_in_q <= accuracy_in_i;
      qi_q     <= quat_i_i;
      qj_q     <= quat_j_i;
      qk_q     <= quat_k_i;
      qr_q     <= quat_real_i;
      yy_q <= '0; yx_q <= '0; ry_q <= '0; rx_q <= '0; n_q <= '0; s_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.mul_en) begin
      p_q <= 64'(mul_a * mul_b);
    end
    if (cmd_i.acc_en) begin
      unique case (cmd_i.acc_idx)
        qth_pkg::P_JR: s_q <= s_q + p2;
        qth_pkg::P_IK: s_q <= s_q - p2;
        qth_pkg::P_II: begin yx_q <= yx_q + pa; rx_q <= rx_q - pa; n_q <= n_q + pa; end
        qth_pkg::P_JJ: begin yx_q <= yx_q - pa; rx_q <= rx_q - pa; n_q <= n_q + pa; end
        qth_pkg::P_KK: begin yx_q <= yx_q - pa; rx_q <= rx_q + pa; n_q <= n_q + pa; end
        qth_pkg::P_RR: begin yx_q <= yx_q + pa; rx_q <= rx_q + pa; n_q <= n_q + pa; end
        qth_pkg::P_IJ: yy_q <= yy_q + p2;
        qth_pkg::P_KR: yy_q <= yy_q + p2;
        qth_pkg::P_JK: ry_q <= ry_q + p2;
        qth_pkg::P_IR: ry_q <= ry_q + p2;
        qth_pkg::P_NN: rad_q <= p_q;
        qth_pkg::P_SS: rad_q <= rad_q - p_q;
        default: ;
      endcase
    end
    if (cmd_i.sqrt_step) begin
      if (rad_q >= sq_trial) begin
        rad_q  <= rad_q - sq_trial;
        root_q <= (root_q >> 1) + sq_bit;
      end else begin
        root_q <= root_q >> 1;
      end
    end
    if (cmd_i.cd_init) begin
      zz_q <= (in_x == '0) && (in_y == '0);
      if (in_x[CW-1]) begin
        cx_q  <= -in_x;
        cy_q  <= -in_y;
        ang_q <= 32'h8000_0000;
      end else begin
        cx_q  <= in_x;
        cy_q  <= in_y;
        ang_q <= '0;
      end
    end
    if (cmd_i.cd_step) begin
      if (!cy_q[CW-1] && (cy_q != '0)) begin
        cx_q  <= cx_q + dx;
        cy_q  <= cy_q - dy;
        ang_q <= ang_q + te;
      end else begin
        cx_q  <= cx_q - dx;
        cy_q  <= cy_q + dy;
        ang_q <= ang_q - te;
      end
    end
    if (cmd_i.cd_store) begin
      unique case (cmd_i.cd_sel)
        qth_pkg::SEL_YAW:  yaw_r_q   <= cd_res;
        qth_pkg::SEL_ROLL: roll_r_q  <= cd_res;
        default:           pitch_r_q <= cd_res;
      endcase
    end
  end

  // configuration, held angles and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= 16'd16384;
      heading_q   <= '0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      roll_q      <= '0;
      acc_hold_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (kind_q) begin
          yaw_q     <= yaw_r_q;
          roll_q    <= roll_r_q;
          pitch_q   <= pitch_r_q;
          heading_q <= yaw_r_q + offset_q;
        end else begin
          acc_hold_q <= acc_in_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heading_angle_o = heading_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_angle_o   = pitch_q;
  assign roll_angle_o    = roll_q;
  assign mag_accuracy_o  = acc_hold_q;

endmodule

// ===== rtl/quaternion_to_heading.sv =====
// Top level of quaternion_to_heading: stream ports, controller and datapath.
//
// Converts rotation-vector quaternions (Q14) into yaw, pitch, roll and heading binary
// angles; magnetometer events only update the stored accuracy. Every event returns one
// result with the held angles. A magnetometer event is accepted and then finished. A
// rotation event is accepted, then takes its products on the shared multiplier, the square
// root (one root bit per cycle) and three passes on the shared CORDIC (initialise, rotate,
// store) and is finished once the output is free. One event is worked on at a time; the
// result register lets the next event be taken while a result waits. Configuration writes
// are always accepted.
`include "quaternion_to_heading_defines.svh"

module quaternion_to_heading #(
  parameter int ANGLE_BITS   = qth_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = qth_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // quat_i, quat_j, quat_k, quat_real, accuracy_in
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // heading, yaw, pitch, roll, mag_accuracy
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  qth_pkg::cmd_t cmd;
  qth_pkg::sts_t sts;
  logic [15:0] heading, yaw, pitch, roll;
  logic [1:0]  mag_acc;

  assign cfg_ready_o  = 1'b1;
  assign sts.in_valid = s_axis_tvalid;
  assign sts.in_kind  = s_axis_tuser;
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  qth_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  qth_datapath #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_kind_i       (s_axis_tuser),
    .quat_i_i        (s_axis_tdata[15:0]),
    .quat_j_i        (s_axis_tdata[31:16]),
    .quat_k_i        (s_axis_tdata[47:32]),
    .quat_real_i     (s_axis_tdata[63:48]),
    .accuracy_in_i   (s_axis_tdata[65:64]),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .heading_angle_o (heading),
    .yaw_angle_o     (yaw),
    .pitch_angle_o   (pitch),
    .roll_angle_o    (roll),
    .mag_accuracy_o  (mag_acc)
  );

  assign m_axis_tdata = {6'd0, mag_acc, roll, pitch, yaw, heading};

  `QTH_ASSERT_IMP(a_finish_slot_free, cmd.finish, sts.out_free, "finish into full output")
  `QTH_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
  `QTH_ASSERT_IMP(a_valid_from_finish, $rose(m_axis_tvalid), $past(cmd.finish), "stray valid")

endmodule
